@@ sv/sqrw_pkg.sv @@
// ----------------------------------------------------------------------------
// sqrw_pkg
// Shared widths, register map, reset values and constants of the
// scale-quantized random walk.
// ----------------------------------------------------------------------------
package sqrw_pkg;

    // item fields
    localparam int NOTE_W     = 7;
    localparam int OUT_NOTE_W = 8;
    localparam int SEED_W     = 32;

    // configuration fields
    localparam int STEP_W = 7;
    localparam int BIAS_W = 16;
    localparam int SIZE_W = 4;
    localparam int DEG_W  = 4;

    localparam int SCALE_MAX_DEF = 12;

    // apb port: one 64-bit slot per register
    localparam int CFG_DATA_W = 64;
    localparam int ADDR_W     = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_MIN_NOTE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_NOTE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STEP_LIMIT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_BIAS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_QUANT_EN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_LEN  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_DEG  = 3'd6;

    localparam logic [NOTE_W-1:0] MIN_NOTE_RESET   = 7'd0;
    localparam logic [NOTE_W-1:0] MAX_NOTE_RESET   = 7'd127;
    localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = 7'd5;
    localparam logic [BIAS_W-1:0] STEP_BIAS_RESET  = 16'd0;
    localparam logic              QUANT_EN_RESET   = 1'b1;
    localparam logic [SIZE_W-1:0] SCALE_LEN_RESET  = 4'd5;
    localparam logic [47:0]       SCALE_DEG_RESET  = 48'h00_0000_097420;

    // item opcodes
    localparam logic OP_STEP    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [SEED_W-1:0] SEED_DEFAULT = 32'd12345;

    // octave split: note / 12 as (note * 43) >> 9, exact for notes below 128
    localparam int NOTES_PER_OCT   = 12;
    localparam int OCT_W           = 4;
    localparam int OCT_RECIP       = 43;
    localparam int OCT_RECIP_SHIFT = 9;

endpackage

@@ sv/sqrw_ifs.sv @@
// ----------------------------------------------------------------------------
// sqrw_ifs
// Valid/ready channels of the random walk: request items in, note items out.
// ----------------------------------------------------------------------------
interface sqrw_in_if import sqrw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [NOTE_W-1:0] start_note;
    logic [SEED_W-1:0] seed;

    modport source (output valid, output op, output start_note, output seed, input ready);
    modport sink   (input valid, input op, input start_note, input seed, output ready);
endinterface

interface sqrw_out_if import sqrw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OUT_NOTE_W-1:0] note;
    logic [NOTE_W-1:0]     raw_note;

    modport source (output valid, output note, output raw_note, input ready);
    modport sink   (input valid, input note, input raw_note, output ready);
endinterface

@@ sv/sqrw_quant.sv @@
// ----------------------------------------------------------------------------
// sqrw_quant
// Snaps a note to the nearest scale degree within its octave; the first
// entry with the smallest distance wins. Off or with scale_len 0, it passes through.
// ----------------------------------------------------------------------------
module sqrw_quant import sqrw_pkg::*; #(
    parameter int SCALE_MAX = SCALE_MAX_DEF
) (
    input  logic [NOTE_W-1:0]          note,
    input  logic                       enable,
    input  logic [SIZE_W-1:0]          scale_len,
    input  logic [DEG_W*SCALE_MAX-1:0] degrees,
    output logic [OUT_NOTE_W-1:0]      quant_note
);

    localparam int LEAVES = 1 << $clog2(SCALE_MAX);
    localparam int NODES  = 2 * LEAVES - 1;

    typedef struct packed {
        logic             valid;
        logic [DEG_W-1:0] gap;
        logic [DEG_W-1:0] entry;
    } node_t;

    logic [OCT_W+NOTE_W+1:0] oct_prod;
    logic [OCT_W-1:0]        octave;
    logic [OUT_NOTE_W-1:0]   oct_base;
    logic [DEG_W-1:0]        degree;
    logic [SIZE_W-1:0]       count;
    node_t                   nodes [NODES];
    logic [DEG_W-1:0]        best;

    always_comb
    begin
        oct_prod = (OCT_W+NOTE_W+2)'(note) * (OCT_W+NOTE_W+2)'(OCT_RECIP);
        octave   = oct_prod[OCT_RECIP_SHIFT +: OCT_W];
        oct_base = OUT_NOTE_W'(octave) * OUT_NOTE_W'(NOTES_PER_OCT);
        degree   = DEG_W'(OUT_NOTE_W'(note) - oct_base);
        count    = (scale_len > SIZE_W'(SCALE_MAX)) ? SIZE_W'(SCALE_MAX) : scale_len;
    end

    // leaves: distance of each degree in use, too far counts as unusable
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            nodes[LEAVES-1+i] = '0;
            if (i < SCALE_MAX)
            begin
                nodes[LEAVES-1+i].entry = degrees[DEG_W*(i % SCALE_MAX) +: DEG_W];
                nodes[LEAVES-1+i].gap   = (nodes[LEAVES-1+i].entry >= degree)
                                        ? nodes[LEAVES-1+i].entry - degree
                                        : degree - nodes[LEAVES-1+i].entry;
                nodes[LEAVES-1+i].valid = (SIZE_W'(i) < count)
                                        && (nodes[LEAVES-1+i].gap < DEG_W'(NOTES_PER_OCT));
            end
        end
        // min tree, left side kept on a tie
        for (int k = LEAVES - 2; k >= 0; k--)
        begin
            if (nodes[2*k+2].valid
                && (!nodes[2*k+1].valid || (nodes[2*k+2].gap < nodes[2*k+1].gap)))
                nodes[k] = nodes[2*k+2];
            else
                nodes[k] = nodes[2*k+1];
        end
    end

    always_comb
    begin
        best = nodes[0].valid ? nodes[0].entry : degrees[DEG_W-1:0];
        if (enable && (count != '0))
            quant_note = oct_base + OUT_NOTE_W'(best);
        else
            quant_note = OUT_NOTE_W'(note);
    end

endmodule

@@ sv/scale_quantized_random_walk.sv @@
// ----------------------------------------------------------------------------
// scale_quantized_random_walk
// Xorshift-driven bounded random walk over notes 0..127 with optional
// quantizing to a programmable scale.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls; a step item runs through
// the stages below, a restart item returns nothing. The generator advances at
// acceptance and the running note is updated one stage before the output
// register, so back-to-back items never wait on each other. Stages: generator
// value, step multiply, add and clamp, scale quantize. The user must write
// configuration over apb only while no item is in flight; the block won't check.
module scale_quantized_random_walk import sqrw_pkg::*; #(
    parameter int SCALE_MAX = SCALE_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    sqrw_in_if.sink               step_in,
    sqrw_out_if.source            note_out
);

    localparam int DEGS_W  = DEG_W * SCALE_MAX;
    localparam int NUMER_W = SEED_W + 3;
    localparam int PROD_W  = NUMER_W + STEP_W + 1;
    localparam int HI_W    = PROD_W - SEED_W;
    localparam int SUM_W   = HI_W + 1;
    localparam logic [DEGS_W-1:0] DEGS_RESET = DEGS_W'(SCALE_DEG_RESET);

    function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // configuration
    logic [NOTE_W-1:0] min_note_reg;
    logic [NOTE_W-1:0] max_note_reg;
    logic [STEP_W-1:0] step_limit_reg;
    logic [BIAS_W-1:0] step_bias_reg;
    logic              quantize_enable_reg;
    logic [SIZE_W-1:0] scale_len_reg;
    logic [DEGS_W-1:0] scale_degrees_reg;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    // walk state and pipeline
    logic [SEED_W-1:0] gen_reg;
    logic [SEED_W-1:0] gen_step;
    logic [SEED_W-1:0] gen_next;
    logic [NOTE_W-1:0] running_reg;
    logic [NOTE_W-1:0] running_next;

    logic en_a, en_b, en_c, en_d, accept;

    logic              a_valid_reg;
    logic              a_op_reg;
    logic [NOTE_W-1:0] a_start_reg;
    logic [SEED_W-1:0] a_u_reg;

    logic              b_valid_reg;
    logic              b_op_reg;
    logic [NOTE_W-1:0] b_start_reg;
    logic [HI_W-1:0]   b_hi_reg;
    logic              b_frac_reg;

    logic              c_valid_reg;
    logic [NOTE_W-1:0] c_raw_reg;

    logic                  d_valid_reg;
    logic [OUT_NOTE_W-1:0] d_note_reg;
    logic [NOTE_W-1:0]     d_raw_reg;

    logic signed [NUMER_W-1:0] numer;
    logic signed [PROD_W-1:0]  prod;
    logic signed [HI_W-1:0]    step;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lo_lim;
    logic signed [SUM_W-1:0]   hi_lim;
    logic signed [SUM_W-1:0]   clamped;
    logic [OUT_NOTE_W-1:0]     q_note;

    // ------------------------------------------------------------------
    // apb registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_note_reg        <= MIN_NOTE_RESET;
            max_note_reg        <= MAX_NOTE_RESET;
            step_limit_reg      <= STEP_LIMIT_RESET;
            step_bias_reg       <= STEP_BIAS_RESET;
            quantize_enable_reg <= QUANT_EN_RESET;
            scale_len_reg       <= SCALE_LEN_RESET;
            scale_degrees_reg   <= DEGS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_NOTE:   min_note_reg        <= pwdata[NOTE_W-1:0];
                REG_MAX_NOTE:   max_note_reg        <= pwdata[NOTE_W-1:0];
                REG_STEP_LIMIT: step_limit_reg      <= pwdata[STEP_W-1:0];
                REG_STEP_BIAS:  step_bias_reg       <= pwdata[BIAS_W-1:0];
                REG_QUANT_EN:   quantize_enable_reg <= pwdata[0];
                REG_SCALE_LEN:  scale_len_reg       <= pwdata[SIZE_W-1:0];
                REG_SCALE_DEG:  scale_degrees_reg   <= pwdata[DEGS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_NOTE:   prdata = CFG_DATA_W'(min_note_reg);
            REG_MAX_NOTE:   prdata = CFG_DATA_W'(max_note_reg);
            REG_STEP_LIMIT: prdata = CFG_DATA_W'(step_limit_reg);
            REG_STEP_BIAS:  prdata = CFG_DATA_W'(step_bias_reg);
            REG_QUANT_EN:   prdata = CFG_DATA_W'(quantize_enable_reg);
            REG_SCALE_LEN:  prdata = CFG_DATA_W'(scale_len_reg);
            REG_SCALE_DEG:  prdata = CFG_DATA_W'(scale_degrees_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow: each stage moves when the one after it has room
    // ------------------------------------------------------------------
    assign en_d   = !d_valid_reg || note_out.ready;
    assign en_c   = !c_valid_reg || en_d;
    assign en_b   = !b_valid_reg || en_c;
    assign en_a   = !a_valid_reg || en_b;
    assign accept = step_in.valid && en_a;

    assign step_in.ready = en_a;

    // generator advances as the item is taken
    always_comb
    begin
        gen_step = xorshift32(gen_reg);
        gen_next = gen_reg;
        if (accept)
        begin
            if (step_in.op == OP_RESTART)
                gen_next = (step_in.seed == '0) ? SEED_DEFAULT : step_in.seed;
            else
                gen_next = gen_step;
        end
    end

    // step = trunc((2u - 2^32 + bias * 2^17) * step_limit / 2^32)
    always_comb
    begin
        numer = $signed({2'b00, a_u_reg, 1'b0})
              - $signed({3'b001, {SEED_W{1'b0}}})
              + $signed({{2{step_bias_reg[BIAS_W-1]}}, step_bias_reg, 17'b0});
        prod  = numer * $signed({1'b0, step_limit_reg});
    end

    // round toward zero, add, clamp to min then max
    always_comb
    begin
        step    = $signed(b_hi_reg) + $signed(HI_W'(b_hi_reg[HI_W-1] && b_frac_reg));
        sum     = $signed({{(SUM_W-NOTE_W){1'b0}}, running_reg}) + SUM_W'(step);
        lo_lim  = $signed({{(SUM_W-NOTE_W){1'b0}}, min_note_reg});
        hi_lim  = $signed({{(SUM_W-NOTE_W){1'b0}}, max_note_reg});
        clamped = (sum < lo_lim) ? lo_lim : sum;
        clamped = (clamped > hi_lim) ? hi_lim : clamped;
        running_next = running_reg;
        if (en_c && b_valid_reg)
        begin
            if (b_op_reg == OP_RESTART)
                running_next = b_start_reg;
            else
                running_next = clamped[NOTE_W-1:0];
        end
    end

    sqrw_quant #(
        .SCALE_MAX (SCALE_MAX)
    ) u_quant (
        .note       (c_raw_reg),
        .enable     (quantize_enable_reg),
        .scale_len  (scale_len_reg),
        .degrees    (scale_degrees_reg),
        .quant_note (q_note)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg     <= SEED_DEFAULT;
            running_reg <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            gen_reg     <= gen_next;
            running_reg <= running_next;
            if (en_a)
                a_valid_reg <= accept;
            if (en_b)
                b_valid_reg <= a_valid_reg;
            // restart items end at the running note
            if (en_c)
                c_valid_reg <= b_valid_reg && (b_op_reg == OP_STEP);
            if (en_d)
                d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_op_reg    <= step_in.op;
            a_start_reg <= step_in.start_note;
            a_u_reg     <= gen_step;
        end
        if (en_b && a_valid_reg)
        begin
            b_op_reg    <= a_op_reg;
            b_start_reg <= a_start_reg;
            b_hi_reg    <= prod[PROD_W-1:SEED_W];
            b_frac_reg  <= |prod[SEED_W-1:0];
        end
        if (en_c && b_valid_reg)
            c_raw_reg <= clamped[NOTE_W-1:0];
        if (en_d && c_valid_reg)
        begin
            d_note_reg <= q_note;
            d_raw_reg  <= c_raw_reg;
        end
    end

    assign note_out.valid    = d_valid_reg;
    assign note_out.note     = d_note_reg;
    assign note_out.raw_note = d_raw_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != '0)
        else $error("generator state went to zero");

    a_seed_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (step_in.op == OP_RESTART) && (step_in.seed != '0)
        |=> gen_reg == $past(step_in.seed))
        else $error("restart seed not loaded");

    a_raw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        note_out.valid && (min_note_reg <= max_note_reg)
        |-> (note_out.raw_note >= min_note_reg) && (note_out.raw_note <= max_note_reg))
        else $error("raw note outside clamp limits");

    a_raw_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        note_out.valid && (!quantize_enable_reg || (scale_len_reg == '0))
        |-> note_out.note == OUT_NOTE_W'(note_out.raw_note))
        else $error("note differs from raw note with quantizing off");

endmodule
